FILE: rtl/core/assert_macros.svh
// Assertion macros used by the walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PTEW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that forces a condition in the next cycle.
`define PTEW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/ptew_pkg.sv
`timescale 1ns / 1ps

package ptew_pkg;

    // Field widths of the request and result items.
    localparam int VA_W    = 48;
    localparam int FRAME_W = 40;
    localparam int PA_W    = 52;
    localparam int DATA_W  = 64;
    localparam int LEVEL_W = 2;

    // Address layout of the four-level tables.
    localparam int PAGE_SHIFT = 12;
    localparam int INDEX_BITS = 9;
    localparam int ENTRY_SHIFT = 3;

    // Entry bits that the walk looks at.
    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    // Table levels.
    localparam logic [LEVEL_W-1:0] LEVEL_TABLE     = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_DIRECTORY = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_POINTER   = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP       = 2'd3;

    typedef enum logic {
        ACTION_START    = 1'b0,
        ACTION_RESPONSE = 1'b1
    } t_action;

    typedef enum logic {
        KIND_READ = 1'b0,
        KIND_DONE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        REASON_REQUESTED   = 2'd0,
        REASON_NOT_PRESENT = 2'd1,
        REASON_LARGE_PAGE  = 2'd2,
        REASON_BOTTOM      = 2'd3
    } t_reason;

    // One result item as it sits in the output buffer.
    typedef struct packed {
        t_kind                kind;
        logic [PA_W-1:0]      entry_address;
        logic [DATA_W-1:0]    entry_value;
        logic [LEVEL_W-1:0]   final_level;
        t_reason              stop_reason;
    } t_result;

    // Table index of the virtual address at a given level.
    function automatic logic [INDEX_BITS-1:0] table_index(
        input logic [LEVEL_W-1:0] level,
        input logic [VA_W-1:0]    va
    );
        logic [INDEX_BITS-1:0] idx;
        case (level)
            LEVEL_TABLE:     idx = va[PAGE_SHIFT +: INDEX_BITS];
            LEVEL_DIRECTORY: idx = va[PAGE_SHIFT + INDEX_BITS +: INDEX_BITS];
            LEVEL_POINTER:   idx = va[PAGE_SHIFT + 2*INDEX_BITS +: INDEX_BITS];
            default:         idx = va[PAGE_SHIFT + 3*INDEX_BITS +: INDEX_BITS];
        endcase
        return idx;
    endfunction

endpackage

FILE: rtl/core/page_table_entry_walker.sv
// Four-level page table walker. A start request carries the virtual address,
// the level to stop at and the root frame; the walker answers with a read
// request for the top-level entry. Each memory response request carries the
// data of the entry last asked for, and the walker answers with either a read
// request one level down or a finished result that gives the final entry's
// address, value, level and stop reason. A response that arrives while no walk
// is active is taken and dropped; a start during a walk abandons that walk.
// A new request may be accepted on every clock while o_ready is high; its
// result goes to the output register on the edge that accepts it, or to the
// skid register if the output is stalled. A two-entry output buffer (output
// register plus skid register) lets the input side take one more request while
// the output is stalled, so i_ready only affects o_ready through a register.
// Entry addresses are masked to PHYS_ADDR_BITS bits.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module page_table_entry_walker #(
    parameter int PHYS_ADDR_BITS = 52
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // Request channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_action,
    input  logic [ptew_pkg::VA_W-1:0]         i_virtual_address,
    input  logic [ptew_pkg::LEVEL_W-1:0]      i_stop_level,
    input  logic [ptew_pkg::FRAME_W-1:0]      i_root_frame,
    input  logic [ptew_pkg::DATA_W-1:0]       i_entry_data,

    // Result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_kind,
    output logic [ptew_pkg::PA_W-1:0]         o_entry_address,
    output logic [ptew_pkg::DATA_W-1:0]       o_entry_value,
    output logic [ptew_pkg::LEVEL_W-1:0]      o_final_level,
    output logic [ptew_pkg::LEVEL_W-1:0]      o_stop_reason
);

    localparam int PaW = ptew_pkg::PA_W;

    // Mask of the implemented physical address bits.
    localparam logic [PaW:0]   PaFull = ((PaW+1)'(1) << PHYS_ADDR_BITS) - (PaW+1)'(1);
    localparam logic [PaW-1:0] PaMask = PaFull[PaW-1:0];

    // Walk state.
    logic                              r_walking;
    logic [ptew_pkg::LEVEL_W-1:0]      r_cur_level;
    logic [ptew_pkg::VA_W-1:0]         r_saved_va;
    logic [ptew_pkg::LEVEL_W-1:0]      r_target_level;
    logic [PaW-1:0]                    r_cur_addr;

    logic                              n_walking;
    logic [ptew_pkg::LEVEL_W-1:0]      n_cur_level;
    logic [ptew_pkg::VA_W-1:0]         n_saved_va;
    logic [ptew_pkg::LEVEL_W-1:0]      n_target_level;
    logic [PaW-1:0]                    n_cur_addr;

    // Output buffer.
    ptew_pkg::t_result                 r_out;
    logic                              r_out_valid;
    ptew_pkg::t_result                 r_skid;
    logic                              r_skid_valid;

    ptew_pkg::t_result                 n_res;
    logic                              n_res_valid;

    logic                              accept;
    logic                              present;
    logic                              large_page;
    logic [ptew_pkg::LEVEL_W-1:0]      down_level;
    logic [PaW-1:0]                    start_addr;
    logic [PaW-1:0]                    down_addr;

    assign o_ready = !r_skid_valid;
    assign accept  = i_valid && o_ready;

    // Entry tests and the addresses of the next entry to read.
    always_comb begin
        present    = i_entry_data[ptew_pkg::PRESENT_BIT];
        large_page = i_entry_data[ptew_pkg::LARGE_BIT]
                     && (r_cur_level == ptew_pkg::LEVEL_DIRECTORY
                         || r_cur_level == ptew_pkg::LEVEL_POINTER);
        down_level = r_cur_level - ptew_pkg::LEVEL_W'(1);
        start_addr = ({i_root_frame, ptew_pkg::PAGE_SHIFT'(0)}
                      | PaW'({ptew_pkg::table_index(ptew_pkg::LEVEL_TOP, i_virtual_address),
                              ptew_pkg::ENTRY_SHIFT'(0)}))
                     & PaMask;
        down_addr  = ({i_entry_data[PaW-1:ptew_pkg::PAGE_SHIFT], ptew_pkg::PAGE_SHIFT'(0)}
                      | PaW'({ptew_pkg::table_index(down_level, r_saved_va),
                              ptew_pkg::ENTRY_SHIFT'(0)}))
                     & PaMask;
    end

    // Next walk state and the result of the accepted request.
    always_comb begin
        n_walking      = r_walking;
        n_cur_level    = r_cur_level;
        n_saved_va     = r_saved_va;
        n_target_level = r_target_level;
        n_cur_addr     = r_cur_addr;
        n_res_valid    = 1'b0;
        n_res.kind          = ptew_pkg::KIND_READ;
        n_res.entry_address = r_cur_addr;
        n_res.entry_value   = '0;
        n_res.final_level   = r_cur_level;
        n_res.stop_reason   = ptew_pkg::REASON_REQUESTED;

        if (accept) begin
            if (i_action == ptew_pkg::ACTION_START) begin
                n_walking           = 1'b1;
                n_cur_level         = ptew_pkg::LEVEL_TOP;
                n_saved_va          = i_virtual_address;
                n_target_level      = i_stop_level;
                n_cur_addr          = start_addr;
                n_res_valid         = 1'b1;
                n_res.entry_address = start_addr;
                n_res.final_level   = ptew_pkg::LEVEL_TOP;
            end else if (r_walking) begin
                n_res_valid = 1'b1;
                if (!present || large_page || r_cur_level == r_target_level
                    || r_cur_level == ptew_pkg::LEVEL_TABLE) begin
                    // The walk ends at this entry.
                    n_walking         = 1'b0;
                    n_res.kind        = ptew_pkg::KIND_DONE;
                    n_res.entry_value = i_entry_data;
                    if (!present) begin
                        n_res.stop_reason = ptew_pkg::REASON_NOT_PRESENT;
                    end else if (large_page) begin
                        n_res.stop_reason = ptew_pkg::REASON_LARGE_PAGE;
                    end else if (r_cur_level == r_target_level) begin
                        n_res.stop_reason = ptew_pkg::REASON_REQUESTED;
                    end else begin
                        n_res.stop_reason = ptew_pkg::REASON_BOTTOM;
                    end
                end else begin
                    // Descend one level and read the next entry.
                    n_cur_level         = down_level;
                    n_cur_addr          = down_addr;
                    n_res.entry_address = down_addr;
                    n_res.final_level   = down_level;
                end
            end
        end
    end

    // Walk state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walking   <= 1'b0;
            r_cur_level <= ptew_pkg::LEVEL_TOP;
        end else begin
            r_walking   <= n_walking;
            r_cur_level <= n_cur_level;
        end
        r_saved_va     <= n_saved_va;
        r_target_level <= n_target_level;
        r_cur_addr     <= n_cur_addr;
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= n_res_valid;
            end
        end else if (n_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (n_res_valid) begin
            r_skid <= n_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_entry_address = r_out.entry_address;
    assign o_entry_value   = r_out.entry_value;
    assign o_final_level   = r_out.final_level;
    assign o_stop_reason   = r_out.stop_reason;

    // Checks on the walker's own logic.
    `PTEW_ASSERT(a_skid_behind_out, i_clk, i_rst_n, !r_skid_valid || r_out_valid, "skid entry full while output register empty")
    `PTEW_ASSERT(a_read_has_no_value, i_clk, i_rst_n, !(o_valid && o_kind == ptew_pkg::KIND_READ) || (o_entry_value == '0 && o_stop_reason == ptew_pkg::REASON_REQUESTED), "read request carries a value or a stop reason")
    `PTEW_ASSERT(a_addr_masked, i_clk, i_rst_n, !o_valid || (o_entry_address & ~PaMask) == '0, "entry address exceeds the physical address width")
    `PTEW_ASSERT_NEXT(a_done_ends_walk, i_clk, i_rst_n, n_res_valid && n_res.kind == ptew_pkg::KIND_DONE, !r_walking, "walk still active after a finished result")

endmodule

FILE: verif/page_table_entry_walker_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the walker, keeps its own copy of the walk state,
// predicts the result of every accepted request that yields one and compares the results.
module page_table_entry_walker_checker
    import ptew_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = 52
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Request channel as seen at the walker's inputs
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  logic                i_action,
    input  logic [VA_W-1:0]     i_virtual_address,
    input  logic [LEVEL_W-1:0]  i_stop_level,
    input  logic [FRAME_W-1:0]  i_root_frame,
    input  logic [DATA_W-1:0]   i_entry_data,

    // Result channel as seen at the walker's outputs
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  logic                i_kind,
    input  logic [PA_W-1:0]     i_entry_address,
    input  logic [DATA_W-1:0]   i_entry_value,
    input  logic [LEVEL_W-1:0]  i_final_level,
    input  logic [LEVEL_W-1:0]  i_stop_reason,

    output int                  o_pending,
    output int                  o_fail_count,
    output int                  o_compared
);

    localparam logic [63:0] ADDR_MASK = (64'd1 << PHYS_ADDR_BITS) - 64'd1;
    localparam logic [63:0] FRAME_MASK = ADDR_MASK & ~((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam int MAX_REPORTS = 50;

    // Walk state of the prediction.
    bit                 walk_active;
    logic [LEVEL_W-1:0] walk_level;
    logic [VA_W-1:0]    walk_va;
    logic [LEVEL_W-1:0] walk_target;
    logic [PA_W-1:0]    walk_entry;

    t_result expected_results[$];
    int      mismatches;
    int      compared;

    // Nine index bits of the virtual address for one level.
    function automatic logic [INDEX_BITS-1:0] va_index(
        input logic [LEVEL_W-1:0] level,
        input logic [VA_W-1:0]    va
    );
        return INDEX_BITS'(va >> (PAGE_SHIFT + INDEX_BITS * level));
    endfunction

    // Address of the entry for one level inside a table at a given base.
    function automatic logic [PA_W-1:0] entry_location(
        input logic [63:0]        table_base,
        input logic [LEVEL_W-1:0] level,
        input logic [VA_W-1:0]    va
    );
        logic [63:0] addr;
        addr = (table_base | (64'(va_index(level, va)) << ENTRY_SHIFT)) & ADDR_MASK;
        return addr[PA_W-1:0];
    endfunction

    // Advances the walk by one accepted request and queues what it causes.
    task automatic predict_walk_step(
        input logic               action,
        input logic [VA_W-1:0]    va,
        input logic [LEVEL_W-1:0] stop,
        input logic [FRAME_W-1:0] frame,
        input logic [DATA_W-1:0]  data
    );
        t_result            res;
        logic [LEVEL_W-1:0] lvl;
        bit                 large_page;
        bit                 stops;
        t_reason            why;
        if (action == ACTION_START) begin
            walk_va     = va;
            walk_target = stop;
            walk_level  = LEVEL_TOP;
            walk_entry  = entry_location(64'(frame) << PAGE_SHIFT, LEVEL_TOP, va);
            walk_active = 1'b1;
            res.kind          = KIND_READ;
            res.entry_address = walk_entry;
            res.entry_value   = '0;
            res.final_level   = LEVEL_TOP;
            res.stop_reason   = REASON_REQUESTED;
            expected_results.push_back(res);
        end else if (walk_active) begin
            lvl        = walk_level;
            large_page = data[LARGE_BIT] && (lvl == LEVEL_POINTER || lvl == LEVEL_DIRECTORY);
            stops      = 1'b1;
            why        = REASON_REQUESTED;
            if (!data[PRESENT_BIT]) begin
                why = REASON_NOT_PRESENT;
            end else if (large_page) begin
                why = REASON_LARGE_PAGE;
            end else if (lvl == walk_target) begin
                why = REASON_REQUESTED;
            end else if (lvl == LEVEL_TABLE) begin
                why = REASON_BOTTOM;
            end else begin
                stops = 1'b0;
            end
            if (stops) begin
                walk_active = 1'b0;
                res.kind          = KIND_DONE;
                res.entry_address = walk_entry;
                res.entry_value   = data;
                res.final_level   = lvl;
                res.stop_reason   = why;
            end else begin
                walk_level = lvl - 1'b1;
                walk_entry = entry_location(data & FRAME_MASK, walk_level, walk_va);
                res.kind          = KIND_READ;
                res.entry_address = walk_entry;
                res.entry_value   = '0;
                res.final_level   = walk_level;
                res.stop_reason   = REASON_REQUESTED;
            end
            expected_results.push_back(res);
        end
    endtask

    // One field of a result against its expected value.
    task automatic compare_field(
        input string       name,
        input logic [63:0] want,
        input logic [63:0] got
    );
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        end
    endtask

    // Compares an accepted result with the oldest expected one.
    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: result with no request waiting, expected none, actual kind %0d address %h",
                         $time, i_kind, i_entry_address);
            end
        end else begin
            want = expected_results.pop_front();
            compare_field("kind", 64'(want.kind), 64'(i_kind));
            compare_field("entry_address", 64'(want.entry_address), 64'(i_entry_address));
            compare_field("entry_value", want.entry_value, i_entry_value);
            compare_field("final_level", 64'(want.final_level), 64'(i_final_level));
            compare_field("stop_reason", 64'(want.stop_reason), 64'(i_stop_reason));
            compared++;
        end
    endtask

    // Results are checked before the request of the same edge is predicted:
    // a request's own result can only appear on a later edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            walk_active = 1'b0;
            walk_level  = LEVEL_TOP;
            walk_va     = '0;
            walk_target = LEVEL_TABLE;
            walk_entry  = '0;
            expected_results.delete();
            mismatches  = 0;
            compared    = 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                check_result();
            end
            if (i_req_valid && i_req_ready) begin
                predict_walk_step(i_action, i_virtual_address, i_stop_level,
                                  i_root_frame, i_entry_data);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
        o_compared   <= compared;
    end

endmodule

FILE: verif/page_table_entry_walker_tb.sv
`timescale 1ns / 1ps

module page_table_entry_walker_tb;

    import ptew_pkg::*;

    localparam int RANDOM_ITEMS   = 930;
    localparam int QUIET_TAIL     = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 16;

    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                i_valid           = 1'b0;
    logic                o_ready;
    logic                i_action          = 1'b0;
    logic [VA_W-1:0]     i_virtual_address = '0;
    logic [LEVEL_W-1:0]  i_stop_level      = '0;
    logic [FRAME_W-1:0]  i_root_frame      = '0;
    logic [DATA_W-1:0]   i_entry_data      = '0;
    logic                o_valid;
    logic                i_ready           = 1'b0;
    logic                o_kind;
    logic [PA_W-1:0]     o_entry_address;
    logic [DATA_W-1:0]   o_entry_value;
    logic [LEVEL_W-1:0]  o_final_level;
    logic [LEVEL_W-1:0]  o_stop_reason;

    int results_pending;
    int mismatch_count;
    int results_compared;

    bit stalls_enabled = 1'b1;
    bit walk_open      = 1'b0;
    int requests_sent  = 0;
    int walks_started  = 0;
    int walks_cut      = 0;
    int stray_count    = 0;
    int ready_hold     = 0;
    int quiet_cycles   = 0;

    page_table_entry_walker #(
        .PHYS_ADDR_BITS (PA_W)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_action          (i_action),
        .i_virtual_address (i_virtual_address),
        .i_stop_level      (i_stop_level),
        .i_root_frame      (i_root_frame),
        .i_entry_data      (i_entry_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_entry_address   (o_entry_address),
        .o_entry_value     (o_entry_value),
        .o_final_level     (o_final_level),
        .o_stop_reason     (o_stop_reason)
    );

    page_table_entry_walker_checker #(
        .PHYS_ADDR_BITS (PA_W)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (i_valid),
        .i_req_ready       (o_ready),
        .i_action          (i_action),
        .i_virtual_address (i_virtual_address),
        .i_stop_level      (i_stop_level),
        .i_root_frame      (i_root_frame),
        .i_entry_data      (i_entry_data),
        .i_res_valid       (o_valid),
        .i_res_ready       (i_ready),
        .i_kind            (o_kind),
        .i_entry_address   (o_entry_address),
        .i_entry_value     (o_entry_value),
        .i_final_level     (o_final_level),
        .i_stop_reason     (o_stop_reason),
        .o_pending         (results_pending),
        .o_fail_count      (mismatch_count),
        .o_compared        (results_compared)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: ready drops in random bursts while stalls are enabled.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            if (ready_hold == 1) begin
                i_ready <= 1'b1;
            end
        end else if (stalls_enabled && $urandom_range(0, 5) == 0) begin
            i_ready    <= 1'b0;
            ready_hold <= $urandom_range(1, 5);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired after %0d idle cycles", $time, WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Presents one request, holds it until accepted, then maybe idles a burst.
    task automatic drive_request(
        input t_action            act,
        input logic [VA_W-1:0]    va,
        input logic [LEVEL_W-1:0] stop,
        input logic [FRAME_W-1:0] frame,
        input logic [DATA_W-1:0]  data
    );
        i_valid           <= 1'b1;
        i_action          <= act;
        i_virtual_address <= va;
        i_stop_level      <= stop;
        i_root_frame      <= frame;
        i_entry_data      <= data;
        do @(posedge i_clk); while (!o_ready);
        requests_sent++;
        if (stalls_enabled && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Start request; the unused data field carries noise.
    task automatic send_start(
        input logic [VA_W-1:0]    va,
        input logic [LEVEL_W-1:0] stop,
        input logic [FRAME_W-1:0] frame
    );
        drive_request(ACTION_START, va, stop, frame, {$urandom, $urandom});
    endtask

    // Memory response request; the unused start fields carry noise.
    task automatic send_response(input logic [DATA_W-1:0] data);
        drive_request(ACTION_RESPONSE, VA_W'({$urandom, $urandom}), LEVEL_W'($urandom),
                      FRAME_W'({$urandom, $urandom}), data);
    endtask

    // Holds the request channel idle until every result has come back.
    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    // One walk with random entries, mostly present; cut >= 0 abandons it
    // after that many responses so the next start overrides it.
    task automatic run_walk(input logic [LEVEL_W-1:0] stop, input int cut);
        logic [DATA_W-1:0]  entry;
        logic [LEVEL_W-1:0] lvl;
        int                 sent;
        bit                 ended;
        send_start(VA_W'({$urandom, $urandom}), stop, FRAME_W'({$urandom, $urandom}));
        walks_started++;
        lvl   = LEVEL_TOP;
        sent  = 0;
        ended = 1'b0;
        while (!ended && sent != cut) begin
            entry = {$urandom, $urandom};
            entry[PRESENT_BIT] = ($urandom_range(0, 9) != 0);
            if (lvl == LEVEL_POINTER || lvl == LEVEL_DIRECTORY) begin
                entry[LARGE_BIT] = ($urandom_range(0, 6) == 0);
            end
            send_response(entry);
            sent++;
            ended = !entry[PRESENT_BIT] || lvl == stop ||
                    (entry[LARGE_BIT] && (lvl == LEVEL_POINTER || lvl == LEVEL_DIRECTORY));
            if (!ended) begin
                lvl = lvl - 1'b1;
            end
        end
        walk_open = !ended;
        if (!ended) begin
            walks_cut++;
        end
    endtask

    initial begin
        int choice;
        bit paused;
        paused = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a response with no walk running is dropped.
        send_response('1);
        // Extreme fields, stop at the top; the large bit is reserved there.
        send_start('1, LEVEL_TOP, '1);
        send_response('1);
        // Full walk to the bottom with zero fields; the large bit at the top
        // and at the page table level does not end the walk.
        send_start('0, LEVEL_TABLE, '0);
        send_response(64'h81);
        send_response(64'h1);
        send_response(64'h1);
        send_response(64'h81);
        // Top entry not present although every other bit is set.
        send_start(VA_W'({$urandom, $urandom}), LEVEL_TABLE, FRAME_W'({$urandom, $urandom}));
        send_response(64'hFFFF_FFFF_FFFF_FFFE);
        // Large page at the pointer level; frame bits above the address width.
        send_start(VA_W'({$urandom, $urandom}), LEVEL_TABLE, FRAME_W'({$urandom, $urandom}));
        send_response(64'hFFF0_0000_0000_0001);
        send_response(64'h81);
        // Large page at the directory level.
        send_start(VA_W'({$urandom, $urandom}), LEVEL_TABLE, FRAME_W'({$urandom, $urandom}));
        send_response(64'h0000_0000_1234_5001);
        send_response(64'h000F_FFFF_FFFF_F001);
        send_response(64'hFFFF_FFFF_FFFF_FFFF);
        // A start in the middle of a walk abandons it.
        send_start(VA_W'({$urandom, $urandom}), LEVEL_DIRECTORY, FRAME_W'({$urandom, $urandom}));
        send_response(64'h1);
        send_start(VA_W'({$urandom, $urandom}), LEVEL_POINTER, FRAME_W'({$urandom, $urandom}));
        send_response(64'h0000_0ABC_DEF0_1001);
        send_response(64'h0000_0000_0000_7001);
        // Stray response after the walk has finished.
        send_response('1);
        stray_count += 2;

        // Hold off until the directed part has fully drained.
        wait_drain();

        // Random walks with a share of abandoned walks and stray responses.
        while (requests_sent - stray_count < RANDOM_ITEMS) begin
            if (requests_sent - stray_count > RANDOM_ITEMS - QUIET_TAIL) begin
                stalls_enabled = 1'b0;
            end
            if (!paused && requests_sent - stray_count > RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                wait_drain();
            end
            choice = $urandom_range(0, 99);
            if (choice < 80) begin
                run_walk($urandom_range(0, 1) ? LEVEL_TABLE : LEVEL_W'($urandom_range(0, 3)), -1);
            end else if (choice < 92) begin
                run_walk(LEVEL_W'($urandom_range(0, 3)), $urandom_range(0, 2));
            end else begin
                if (!walk_open) begin
                    stray_count++;
                end
                send_response({$urandom, $urandom});
                walk_open = 1'b0;
            end
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d requests sent: %0d walks, %0d of them abandoned, %0d stray responses",
                 requests_sent, walks_started, walks_cut, stray_count);
        $display("summary: %0d results compared, %0d mismatches",
                 results_compared, mismatch_count);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
